>>> hw/rtl/cst_pkg.sv
// ----------------------------------------------------------------------------
// cst_pkg
// Shared types and operation codes for the counting semaphore table.
// ----------------------------------------------------------------------------
package cst_pkg;

   typedef enum logic [2:0] {
      OP_ALLOC = 3'd0,
      OP_FREE  = 3'd1,
      OP_WAIT  = 3'd2,
      OP_SIGNAL = 3'd3,
      OP_READ  = 3'd4,
      OP_SET   = 3'd5,
      OP_EXIT  = 3'd6,
      OP_BAD   = 3'd7
   } op_type;

   typedef struct packed {
      logic [2:0]         operation;
      logic [4:0]         sem_id;
      logic signed [15:0] count_value;
      logic [4:0]         proc_id;
   } req_type;

   typedef struct packed {
      logic               status;
      logic [4:0]         granted_sem;
      logic signed [15:0] current_count;
      logic               caller_blocked;
      logic               woken_valid;
      logic [4:0]         woken_proc;
      logic               last_result;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load;     // capture request
      logic exec;     // perform operation (or one free step)
      logic finish;   // free epilogue: return the semaphore to the free list
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_free;  // request is a valid free
      logic more;     // free queue still has a waiter
   } sts_type;

endpackage

>>> hw/rtl/cst_ctrl.sv
// ----------------------------------------------------------------------------
// cst_ctrl
// Sequencer: accept a beat, execute, step free through its queue, emit beats.
// ----------------------------------------------------------------------------
module cst_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic             rsp_stall,
   output logic             rsp_valid,
   output cst_pkg::cmd_type cmd,
   input  cst_pkg::sts_type sts
);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_EXEC = 4'b0010,
      S_FREE = 4'b0100,
      S_OUT  = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      vld_ff, vld_in;
   logic      last_ff, last_in;

   assign req_stall = !(state_ff == S_IDLE);
   assign rsp_valid = vld_ff;

   always_comb begin
      state_in = state_ff;
      vld_in = vld_ff;
      last_in = last_ff;
      cmd = '0;
      if (vld_ff && !rsp_stall) vld_in = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (sts.is_free) begin
               state_in = S_FREE;
            end else if (!vld_in) begin
               cmd.exec = 1'b1;
               vld_in = 1'b1;
               last_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_FREE: begin
            // one waiter per beat; the closing beat also retires the semaphore
            if (!vld_in) begin
               cmd.exec = 1'b1;
               vld_in = 1'b1;
               if (!sts.more || last_ff) begin
                  cmd.finish = 1'b1;
                  state_in = S_OUT;
               end
            end
         end
         S_OUT: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         vld_ff <= 1'b0;
         last_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         vld_ff <= vld_in;
         last_ff <= (state_ff == S_IDLE) ? 1'b0 : last_in;
      end
   end

endmodule

>>> hw/rtl/cst_datapath.sv
// ----------------------------------------------------------------------------
// cst_datapath
// Semaphore and process tables with the link update logic.
// ----------------------------------------------------------------------------
module cst_datapath #(
   parameter int NUM_SEMS = 32,
   parameter int NUM_PROCS = 32,
   parameter int COUNT_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  cst_pkg::req_type req,
   input  cst_pkg::cmd_type cmd,
   output cst_pkg::sts_type sts,
   output cst_pkg::rsp_type rsp
);

   localparam int SW = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
   localparam int PW = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
   localparam logic [SW:0] SNIL = '1;
   localparam logic [PW:0] PNIL = '1;
   localparam logic signed [COUNT_BITS-1:0] CMAX = {1'b0, {(COUNT_BITS-1){1'b1}}};
   localparam logic signed [COUNT_BITS-1:0] CMIN = {1'b1, {(COUNT_BITS-1){1'b0}}};

   logic signed [COUNT_BITS-1:0] cnt_ff [NUM_SEMS];
   logic [PW:0] head_ff [NUM_SEMS];
   logic [PW:0] tail_ff [NUM_SEMS];
   logic [SW:0] fnext_ff [NUM_SEMS];
   logic [NUM_SEMS-1:0] use_ff;
   logic [SW:0] fhead_ff;
   logic [PW:0] prev_ff [NUM_PROCS];
   logic [PW:0] next_ff [NUM_PROCS];
   logic [SW:0] won_ff [NUM_PROCS];
   cst_pkg::req_type r_ff;
   cst_pkg::rsp_type rsp_ff, rsp_in;

   logic s_ok, p_ok;
   logic [SW-1:0] si;
   logic [PW-1:0] pi;
   logic [PW:0] unl;          // process to unlink
   logic [SW:0] us;
   logic [PW:0] upv, unx;
   logic signed [COUNT_BITS-1:0] cur, dec, inc, ecnt, val;
   logic [SW-1:0] esi;
   logic [PW:0] hd;
   logic is_free_op;

   always_comb begin
      s_ok = {{(32-5){1'b0}}, r_ff.sem_id} < NUM_SEMS;
      p_ok = {{(32-5){1'b0}}, r_ff.proc_id} < NUM_PROCS;
      si = SW'(r_ff.sem_id);
      pi = PW'(r_ff.proc_id);
      is_free_op = (cst_pkg::op_type'(r_ff.operation) == cst_pkg::OP_FREE) && s_ok;
      hd = head_ff[si];
      cur = cnt_ff[si];
      dec = (cur == CMIN) ? CMIN : cur - 1'b1;
      inc = (cur == CMAX) ? CMAX : cur + 1'b1;
      val = (COUNT_BITS >= 16) ? COUNT_BITS'(r_ff.count_value)
            : ((r_ff.count_value > 16'(signed'(CMAX))) ? CMAX
            : (r_ff.count_value < 16'(signed'(CMIN))) ? CMIN
            : COUNT_BITS'(r_ff.count_value));
      // exit target
      esi = SW'(won_ff[pi]);
      ecnt = (cnt_ff[esi] == CMAX) ? CMAX : cnt_ff[esi] + 1'b1;
      unl = PNIL;
      unique case (cst_pkg::op_type'(r_ff.operation))
         cst_pkg::OP_FREE: if (s_ok) unl = hd;
         cst_pkg::OP_SIGNAL: if (s_ok && inc <= 0) unl = hd;
         cst_pkg::OP_EXIT: if (p_ok) unl = {1'b0, pi};
         default: unl = PNIL;
      endcase
      if (unl[PW]) begin
         us = SNIL; upv = PNIL; unx = PNIL;
      end else begin
         us = won_ff[unl[PW-1:0]];
         upv = prev_ff[unl[PW-1:0]];
         unx = next_ff[unl[PW-1:0]];
      end
      sts.is_free = is_free_op;
      // another waiter stands behind the head
      sts.more = !hd[PW] && !unx[PW];
   end

   always_comb begin
      rsp_in = '0;
      rsp_in.last_result = 1'b1;
      unique case (cst_pkg::op_type'(r_ff.operation))
         cst_pkg::OP_ALLOC: begin
            if (fhead_ff[SW]) rsp_in.status = 1'b1;
            else rsp_in.granted_sem = 5'(fhead_ff[SW-1:0]);
         end
         cst_pkg::OP_FREE: begin
            if (!s_ok) rsp_in.status = 1'b1;
            else begin
               rsp_in.woken_valid = !hd[PW];
               rsp_in.woken_proc = hd[PW] ? 5'd0 : 5'(hd[PW-1:0]);
               rsp_in.last_result = cmd.finish;
            end
         end
         cst_pkg::OP_WAIT: begin
            if (!s_ok || !p_ok || !won_ff[pi][SW]) rsp_in.status = 1'b1;
            else rsp_in.caller_blocked = (dec < 0);
         end
         cst_pkg::OP_SIGNAL: begin
            if (!s_ok) rsp_in.status = 1'b1;
            else if (!unl[PW]) begin
               rsp_in.woken_valid = 1'b1;
               rsp_in.woken_proc = 5'(unl[PW-1:0]);
            end
         end
         cst_pkg::OP_READ: begin
            if (!s_ok) rsp_in.status = 1'b1;
            else rsp_in.current_count = 16'(cur);
         end
         cst_pkg::OP_SET: rsp_in.status = !s_ok;
         cst_pkg::OP_EXIT: rsp_in.status = !p_ok;
         default: rsp_in.status = 1'b1;
      endcase
   end

   assign rsp = rsp_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) r_ff <= req;
      if (reset) begin
         for (int i = 0; i < NUM_SEMS; i++) begin
            cnt_ff[i] <= '0;
            head_ff[i] <= PNIL;
            tail_ff[i] <= PNIL;
            fnext_ff[i] <= (i + 1 < NUM_SEMS) ? (SW+1)'(i + 1) : SNIL;
         end
         use_ff <= '0;
         fhead_ff <= '0;
         for (int j = 0; j < NUM_PROCS; j++) begin
            prev_ff[j] <= PNIL;
            next_ff[j] <= PNIL;
            won_ff[j] <= SNIL;
         end
      end else if (cmd.exec) begin
         rsp_ff <= rsp_in;
         // generic unlink
         if (!unl[PW] && !us[SW]) begin
            if (upv[PW]) head_ff[us[SW-1:0]] <= unx;
            else next_ff[upv[PW-1:0]] <= unx;
            if (unx[PW]) tail_ff[us[SW-1:0]] <= upv;
            else prev_ff[unx[PW-1:0]] <= upv;
            prev_ff[unl[PW-1:0]] <= PNIL;
            next_ff[unl[PW-1:0]] <= PNIL;
            won_ff[unl[PW-1:0]] <= SNIL;
         end
         unique case (cst_pkg::op_type'(r_ff.operation))
            cst_pkg::OP_ALLOC: begin
               if (!fhead_ff[SW]) begin
                  use_ff[fhead_ff[SW-1:0]] <= 1'b1;
                  cnt_ff[fhead_ff[SW-1:0]] <= val;
                  fhead_ff <= fnext_ff[fhead_ff[SW-1:0]];
               end
            end
            cst_pkg::OP_FREE: begin
               // the unlink of the last waiter already empties the queue
               if (s_ok && cmd.finish && use_ff[si]) begin
                  use_ff[si] <= 1'b0;
                  fnext_ff[si] <= fhead_ff;
                  fhead_ff <= {1'b0, si};
               end
            end
            cst_pkg::OP_WAIT: begin
               if (s_ok && p_ok && won_ff[pi][SW]) begin
                  cnt_ff[si] <= dec;
                  if (dec < 0) begin
                     if (!hd[PW] && !tail_ff[si][PW]) begin
                        prev_ff[pi] <= tail_ff[si];
                        next_ff[tail_ff[si][PW-1:0]] <= {1'b0, pi};
                     end else begin
                        head_ff[si] <= {1'b0, pi};
                        prev_ff[pi] <= PNIL;
                     end
                     next_ff[pi] <= PNIL;
                     won_ff[pi] <= {1'b0, si};
                     tail_ff[si] <= {1'b0, pi};
                  end
               end
            end
            cst_pkg::OP_SIGNAL: begin
               if (s_ok) cnt_ff[si] <= inc;
            end
            cst_pkg::OP_SET: begin
               if (s_ok) cnt_ff[si] <= val;
            end
            cst_pkg::OP_EXIT: begin
               if (p_ok && !won_ff[pi][SW]) cnt_ff[esi] <= ecnt;
            end
            default: ;
         endcase
      end
   end

endmodule

>>> hw/rtl/counting_semaphore_table.sv
// ----------------------------------------------------------------------------
// counting_semaphore_table
// Semaphore engine with per-semaphore FIFO wait queues of process ids.
// ----------------------------------------------------------------------------
// One beat is handled at a time: an accepted request is captured, executed in
// the EXEC state and its result beat registered, and the next request is taken
// once the sequencer is back in idle; a stalled result holds the sequencer.
// Free presents one beat per woken waiter (one beat when the queue is empty),
// one per cycle while the result is not stalled, as the single update port
// steps the wait queue. Every other operation returns one result beat;
// last_result marks the final beat of a free.
module counting_semaphore_table #(
   parameter int NUM_SEMS = 32,
   parameter int NUM_PROCS = 32,
   parameter int COUNT_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  cst_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output cst_pkg::rsp_type rsp_data
);

   cst_pkg::cmd_type cmd;
   cst_pkg::sts_type sts;

   cst_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_stall, .rsp_valid,
      .cmd, .sts
   );

   cst_datapath #(
      .NUM_SEMS(NUM_SEMS), .NUM_PROCS(NUM_PROCS), .COUNT_BITS(COUNT_BITS)
   ) u_dp (
      .clock, .reset, .req(req_data), .cmd, .sts, .rsp(rsp_data)
   );

`ifndef SYNTH
   a_no_exec_while_full: assert property (@(posedge clock) disable iff (reset)
      cmd.exec |-> !rsp_valid || !rsp_stall) else $error("result overwritten");
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> !req_stall) else $error("load while busy");
   a_finish_exec: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> cmd.exec) else $error("finish without exec");
`endif

endmodule

>>> test/cst_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cst_checker
// Watches both channels of the semaphore table, predicts every result beat
// from the accepted request beats and compares them field by field.
// ----------------------------------------------------------------------------
module cst_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  cst_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  cst_pkg::rsp_type rsp_data,
   output int               fail_count,
   output int               pending
);

   localparam int NSEM = 32;
   localparam int NPROC = 32;
   localparam logic [5:0] NIL = 6'h3f;

   int         count_tbl [NSEM];
   logic [5:0] head_tbl [NSEM];
   logic [5:0] tail_tbl [NSEM];
   logic [5:0] free_link [NSEM];
   logic       in_use [NSEM];
   logic [5:0] free_top;
   logic [5:0] prev_link [NPROC];
   logic [5:0] next_link [NPROC];
   logic [5:0] waits_on [NPROC];

   cst_pkg::rsp_type expected_beats[$];

   assign pending = expected_beats.size();

   function automatic int clamp16(int v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   function automatic cst_pkg::rsp_type beat(logic st, logic [4:0] g, int c, logic blk,
                                             logic wv, logic [4:0] wp, logic last);
      cst_pkg::rsp_type r;
      r.status = st;
      r.granted_sem = g;
      r.current_count = c[15:0];
      r.caller_blocked = blk;
      r.woken_valid = wv;
      r.woken_proc = wp;
      r.last_result = last;
      return r;
   endfunction

   task automatic clear_tables();
      for (int i = 0; i < NSEM; i++) begin
         count_tbl[i] = 0;
         head_tbl[i] = NIL;
         tail_tbl[i] = NIL;
         free_link[i] = (i + 1 < NSEM) ? 6'(i + 1) : NIL;
         in_use[i] = 0;
      end
      free_top = 0;
      for (int i = 0; i < NPROC; i++) begin
         prev_link[i] = NIL;
         next_link[i] = NIL;
         waits_on[i] = NIL;
      end
   endtask

   task automatic unlink(int p);
      logic [5:0] s, pv, nx;
      s = waits_on[p];
      pv = prev_link[p];
      nx = next_link[p];
      if (s >= NSEM) return;
      if (pv >= NPROC) head_tbl[s] = (nx < NPROC) ? nx : NIL;
      else next_link[pv] = (nx < NPROC) ? nx : NIL;
      if (nx >= NPROC) tail_tbl[s] = (pv < NPROC) ? pv : NIL;
      else prev_link[nx] = (pv < NPROC) ? pv : NIL;
      prev_link[p] = NIL;
      next_link[p] = NIL;
      waits_on[p] = NIL;
   endtask

   task automatic predict_semaphore_op(cst_pkg::req_type rq);
      int s, p, k, w;
      logic wv;
      logic [4:0] wp;
      s = rq.sem_id;
      p = rq.proc_id;
      case (cst_pkg::op_type'(rq.operation))
         cst_pkg::OP_ALLOC: begin
            if (free_top >= NSEM) begin
               expected_beats.push_back(beat(1, 0, 0, 0, 0, 0, 1));
            end else begin
               w = free_top;
               in_use[w] = 1;
               count_tbl[w] = rq.count_value;
               free_top = free_link[w];
               expected_beats.push_back(beat(0, 5'(w), 0, 0, 0, 0, 1));
            end
         end
         cst_pkg::OP_FREE: begin
            k = 0;
            while (head_tbl[s] < NPROC) begin
               w = head_tbl[s];
               unlink(w);
               expected_beats.push_back(beat(0, 0, 0, 0, 1, 5'(w), 0));
               k++;
            end
            head_tbl[s] = NIL;
            tail_tbl[s] = NIL;
            if (in_use[s]) begin
               in_use[s] = 0;
               free_link[s] = free_top;
               free_top = 6'(s);
            end
            if (k == 0) expected_beats.push_back(beat(0, 0, 0, 0, 0, 0, 1));
            else expected_beats[$].last_result = 1;
         end
         cst_pkg::OP_WAIT: begin
            if (waits_on[p] != NIL) begin
               expected_beats.push_back(beat(1, 0, 0, 0, 0, 0, 1));
            end else begin
               count_tbl[s] = clamp16(count_tbl[s] - 1);
               if (count_tbl[s] < 0) begin
                  if (head_tbl[s] != NIL && tail_tbl[s] < NPROC) begin
                     prev_link[p] = tail_tbl[s];
                     next_link[tail_tbl[s]] = 6'(p);
                  end else begin
                     head_tbl[s] = 6'(p);
                     prev_link[p] = NIL;
                  end
                  next_link[p] = NIL;
                  waits_on[p] = 6'(s);
                  tail_tbl[s] = 6'(p);
               end
               expected_beats.push_back(beat(0, 0, 0, count_tbl[s] < 0, 0, 0, 1));
            end
         end
         cst_pkg::OP_SIGNAL: begin
            wv = 0;
            wp = 0;
            count_tbl[s] = clamp16(count_tbl[s] + 1);
            if (count_tbl[s] <= 0 && head_tbl[s] < NPROC) begin
               wp = head_tbl[s][4:0];
               unlink(wp);
               wv = 1;
            end
            expected_beats.push_back(beat(0, 0, 0, 0, wv, wp, 1));
         end
         cst_pkg::OP_READ: expected_beats.push_back(beat(0, 0, count_tbl[s], 0, 0, 0, 1));
         cst_pkg::OP_SET: begin
            count_tbl[s] = rq.count_value;
            expected_beats.push_back(beat(0, 0, 0, 0, 0, 0, 1));
         end
         cst_pkg::OP_EXIT: begin
            w = waits_on[p];
            if (w < NSEM) begin
               unlink(p);
               count_tbl[w] = clamp16(count_tbl[w] + 1);
            end
            expected_beats.push_back(beat(0, 0, 0, 0, 0, 0, 1));
         end
         default: expected_beats.push_back(beat(1, 0, 0, 0, 0, 0, 1));
      endcase
   endtask

   task automatic check_field(string name, longint exp_v, longint act_v);
      if (exp_v != act_v) begin
         $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      cst_pkg::rsp_type e;
      if (reset) begin
         clear_tables();
         expected_beats.delete();
         fail_count = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_beats.size() == 0) begin
               $error("unexpected result beat %p", rsp_data);
               fail_count++;
            end else begin
               e = expected_beats.pop_front();
               check_field("status", e.status, rsp_data.status);
               check_field("granted_sem", e.granted_sem, rsp_data.granted_sem);
               check_field("current_count", e.current_count, rsp_data.current_count);
               check_field("caller_blocked", e.caller_blocked, rsp_data.caller_blocked);
               check_field("woken_valid", e.woken_valid, rsp_data.woken_valid);
               check_field("woken_proc", e.woken_proc, rsp_data.woken_proc);
               check_field("last_result", e.last_result, rsp_data.last_result);
            end
         end
         if (req_valid && !req_stall) predict_semaphore_op(req_data);
      end
   end
endmodule

>>> test/tb_counting_semaphore_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_counting_semaphore_table
// Drives directed and random semaphore operations with random gaps and
// stalls; the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_counting_semaphore_table;

   logic             clock = 0;
   logic             reset = 1;
   logic             req_valid = 0;
   logic             req_stall;
   cst_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 0;
   cst_pkg::rsp_type rsp_data;
   int               fail_count;
   int               pending;
   int               send_idle_pct = 0;
   int               recv_idle_pct = 0;

   always #5 clock = ~clock;

   counting_semaphore_table dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   cst_checker checker_i (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .fail_count(fail_count), .pending(pending)
   );

   always @(negedge clock) begin
      if (!reset) rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // hold the beat until accepted, then drop valid only if idling next
   task automatic send_op(cst_pkg::op_type op, int sem, int cnt, int proc);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_data <= '{operation: op, sem_id: 5'(sem), count_value: 16'(cnt),
                    proc_id: 5'(proc)};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_random();
      int r;
      r = $urandom_range(99);
      if (r < 8) send_op(cst_pkg::OP_ALLOC, 0, $urandom_range(6) - 2, 0);
      else if (r < 12) send_op(cst_pkg::OP_FREE, $urandom_range(31), 0, 0);
      else if (r < 42) send_op(cst_pkg::OP_WAIT, $urandom_range(7), 0, $urandom_range(31));
      else if (r < 62) send_op(cst_pkg::OP_SIGNAL, $urandom_range(7), 0, $urandom);
      else if (r < 72) send_op(cst_pkg::OP_READ, $urandom_range(31), 0, 0);
      else if (r < 80) send_op(cst_pkg::OP_SET, $urandom_range(7),
                               ($urandom_range(3) == 0) ? $urandom : $urandom_range(4),
                               0);
      else if (r < 92) send_op(cst_pkg::OP_EXIT, 0, 0, $urandom_range(31));
      else send_op(cst_pkg::op_type'($urandom_range(7)), $urandom, $urandom, $urandom);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      // directed: extremes, every code, saturation, queue order
      send_op(cst_pkg::OP_ALLOC, 0, -32768, 0);
      send_op(cst_pkg::OP_ALLOC, 0, 32767, 0);
      send_op(cst_pkg::OP_SIGNAL, 1, 0, 0);
      send_op(cst_pkg::OP_READ, 1, 0, 0);
      send_op(cst_pkg::OP_WAIT, 0, 0, 31);
      send_op(cst_pkg::OP_WAIT, 0, 0, 31);
      send_op(cst_pkg::OP_WAIT, 0, 0, 5);
      send_op(cst_pkg::OP_WAIT, 0, 0, 9);
      send_op(cst_pkg::OP_EXIT, 0, 0, 5);
      send_op(cst_pkg::OP_READ, 0, 0, 0);
      send_op(cst_pkg::OP_SET, 0, -1, 0);
      send_op(cst_pkg::OP_SIGNAL, 0, 0, 0);
      send_op(cst_pkg::OP_WAIT, 31, 0, 0);
      send_op(cst_pkg::OP_WAIT, 31, 0, 1);
      send_op(cst_pkg::OP_FREE, 0, 0, 0);
      send_op(cst_pkg::OP_FREE, 31, 0, 0);
      send_op(cst_pkg::OP_FREE, 0, 0, 0);
      send_op(cst_pkg::OP_EXIT, 0, 0, 2);
      send_op(cst_pkg::OP_BAD, 31, 32767, 31);
      send_op(cst_pkg::OP_SIGNAL, 31, 0, 0);
      send_op(cst_pkg::OP_SIGNAL, 31, 0, 0);
      for (int i = 0; i < 33; i++) send_op(cst_pkg::OP_ALLOC, 0, i, 0);
      // every process waits on one queue; those that block are released by free
      for (int i = 0; i < 32; i++) send_op(cst_pkg::OP_WAIT, 3, 0, i);
      send_op(cst_pkg::OP_FREE, 3, 0, 0);
      req_valid <= 0;
      wait (pending == 0);
      @(negedge clock);
      send_idle_pct = 13;
      recv_idle_pct = 80;
      for (int i = 0; i < 120; i++) send_random();
      req_valid <= 0;
      wait (pending == 0);
      @(negedge clock);
      send_idle_pct = 80;
      recv_idle_pct = 13;
      for (int i = 0; i < 120; i++) send_random();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      for (int i = 0; i < 120; i++) send_random();
      req_valid <= 0;
      wait (pending == 0);
      repeat (50) @(posedge clock);
      if (fail_count == 0) $display("counting_semaphore_table regression: pass");
      else $display("counting_semaphore_table regression: fail");
      $finish;
   end

   initial begin
      #20ms;
      $display("counting_semaphore_table regression: fail");
      $finish;
   end
endmodule
